// ===== rtl/wchms_pkg.sv =====
package wchms_pkg;

  localparam int unsigned StrLen = 11;
  localparam int unsigned IdxW   = 4;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(StrLen - 1);

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharZero  = 8'h30;

  localparam logic signed [13:0] HourLimit   = 14'sd24;
  localparam logic signed [13:0] MinSecLimit = 14'sd60;
  localparam logic [4:0] HourMax   = 5'd23;
  localparam logic [5:0] MinSecMax = 6'd59;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_STOP = 2'd2,
    CMD_TICK = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] min_tens;
    logic [3:0] min_ones;
    logic [2:0] sec_tens;
    logic [3:0] sec_ones;
  } time_digits_t;

  typedef struct packed {
    logic         load;
    time_digits_t digits;
  } emit_req_t;

  function automatic logic signed [13:0] two_digit(logic [7:0] tens, logic [7:0] ones);
    logic signed [13:0] t;
    logic signed [13:0] o;
    t = $signed({6'd0, tens}) - $signed({6'd0, CharZero});
    o = $signed({6'd0, ones}) - $signed({6'd0, CharZero});
    return (t <<< 3) + (t <<< 1) + o;
  endfunction

  // Split a value below 60 into tens and ones.
  function automatic logic [6:0] split_dec(logic [5:0] v);
    logic [2:0] tens;
    logic [5:0] ones;
    if (v >= 6'd50) begin
      tens = 3'd5;
    end else if (v >= 6'd40) begin
      tens = 3'd4;
    end else if (v >= 6'd30) begin
      tens = 3'd3;
    end else if (v >= 6'd20) begin
      tens = 3'd2;
    end else if (v >= 6'd10) begin
      tens = 3'd1;
    end else begin
      tens = 3'd0;
    end
    ones = v - ({tens, 3'd0} + {2'd0, tens, 1'b0});
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [7:0] char_at(logic [IdxW-1:0] idx, time_digits_t d);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = CharCr;
      4'd1:    c = CharZero + {6'd0, d.hour_tens};
      4'd2:    c = CharZero + {4'd0, d.hour_ones};
      4'd3:    c = CharColon;
      4'd4:    c = CharZero + {5'd0, d.min_tens};
      4'd5:    c = CharZero + {4'd0, d.min_ones};
      4'd6:    c = CharColon;
      4'd7:    c = CharZero + {5'd0, d.sec_tens};
      4'd8:    c = CharZero + {4'd0, d.sec_ones};
      4'd9:    c = CharCr;
      default: c = CharNul;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/wchms_time.sv =====
module wchms_time
  import wchms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [1:0] cmd_i,
  input  logic [7:0] hour_tens_char_i,
  input  logic [7:0] hour_ones_char_i,
  input  logic [7:0] minute_tens_char_i,
  input  logic [7:0] minute_ones_char_i,
  input  logic [7:0] second_tens_char_i,
  input  logic [7:0] second_ones_char_i,
  output logic       emit_o,
  output time_digits_t digits_o
);

  logic [4:0] hours_q, hours_d;
  logic [5:0] minutes_q, minutes_d;
  logic [5:0] seconds_q, seconds_d;
  logic       running_q, running_d;

  logic signed [13:0] h_v, m_v, s_v;
  logic               set_ok;
  logic [6:0]         h_dec, m_dec, s_dec;

  assign h_v = two_digit(hour_tens_char_i, hour_ones_char_i);
  assign m_v = two_digit(minute_tens_char_i, minute_ones_char_i);
  assign s_v = two_digit(second_tens_char_i, second_ones_char_i);
  assign set_ok = (h_v >= 14'sd0) && (h_v < HourLimit) &&
                  (m_v >= 14'sd0) && (m_v < MinSecLimit) &&
                  (s_v >= 14'sd0) && (s_v < MinSecLimit);

  always_comb begin
    hours_d   = hours_q;
    minutes_d = minutes_q;
    seconds_d = seconds_q;
    running_d = running_q;
    emit_o    = 1'b0;
    unique case (cmd_e'(cmd_i))
      CMD_SET: begin
        if (set_ok) begin
          hours_d   = h_v[4:0];
          minutes_d = m_v[5:0];
          seconds_d = s_v[5:0];
          running_d = 1'b1;
          emit_o    = 1'b1;
        end
      end
      CMD_GET: begin
        emit_o = 1'b1;
      end
      CMD_STOP: begin
        running_d = 1'b0;
      end
      CMD_TICK: begin
        if (running_q) begin
          emit_o = 1'b1;
          if (seconds_q >= MinSecMax) begin
            seconds_d = 6'd0;
            if (minutes_q >= MinSecMax) begin
              minutes_d = 6'd0;
              hours_d   = (hours_q >= HourMax) ? 5'd0 : hours_q + 5'd1;
            end else begin
              minutes_d = minutes_q + 6'd1;
            end
          end else begin
            seconds_d = seconds_q + 6'd1;
          end
        end
      end
      default: begin
        emit_o = 1'b0;
      end
    endcase
  end

  assign h_dec = split_dec({1'b0, hours_d});
  assign m_dec = split_dec(minutes_d);
  assign s_dec = split_dec(seconds_d);

  assign digits_o = '{
    hour_tens: h_dec[5:4],
    hour_ones: h_dec[3:0],
    min_tens:  m_dec[6:4],
    min_ones:  m_dec[3:0],
    sec_tens:  s_dec[6:4],
    sec_ones:  s_dec[3:0]
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hours_q   <= '0;
      minutes_q <= '0;
      seconds_q <= '0;
      running_q <= 1'b0;
    end else if (take_i) begin
      hours_q   <= hours_d;
      minutes_q <= minutes_d;
      seconds_q <= seconds_d;
      running_q <= running_d;
    end
  end

endmodule

// ===== rtl/wchms_emit.sv =====
module wchms_emit
  import wchms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  emit_req_t  req_i,
  output logic       ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o
);

  logic            valid_q;
  logic            last_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] idx_next;
  time_digits_t    digits_q;
  logic [7:0]      out_char_q;
  logic            advance;

  assign idx_next = idx_q + IdxW'(1);
  assign advance  = valid_q && out_ready_i && !last_q;
  assign ready_o  = !valid_q || (out_ready_i && last_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      idx_q   <= '0;
    end else if (req_i.load) begin
      valid_q <= 1'b1;
      last_q  <= 1'b0;
      idx_q   <= '0;
    end else if (valid_q && out_ready_i) begin
      if (last_q) begin
        valid_q <= 1'b0;
      end else begin
        idx_q  <= idx_next;
        last_q <= (idx_next == LastIdx);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      digits_q   <= req_i.digits;
      out_char_q <= CharCr;
    end else if (advance) begin
      out_char_q <= char_at(idx_next, digits_q);
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = out_char_q;
  assign last_char_o = last_q;

endmodule

// ===== rtl/wall_clock_hms_ascii_unit.sv =====
// 24-hour wall clock with set, get, stop and tick commands.
// Input channel: in_valid_i / in_ready_o carry one command word with six
// ASCII digit bytes (used by set only). Output channel: out_valid_o /
// out_ready_i carry the time string one byte per word: CR, HH:MM:SS, CR,
// NUL, with last_char_o high on the NUL.
// A command word lands in an input register and is decoded against the
// held time once it can be taken; a displaying command then loads the
// byte serializer, whose first byte is offered from a register.
// A displaying command (valid set, get, tick while running) occupies the
// serializer for all 11 bytes, one byte per cycle while the receiver is
// ready; stop, invalid set and tick while stopped produce no bytes and
// are taken without waiting for the serializer.
// The next word is taken while a string is still being sent; it waits in
// the input register until the serializer frees up at its final byte.
// Reset clears the time to 00:00:00 with the clock stopped and drops any
// pending bytes. When the receiver stalls, the current byte holds, and
// in_ready_o drops once the input register is full.
module wall_clock_hms_ascii_unit
  import wchms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] hour_tens_char_i,
  input  logic [7:0] hour_ones_char_i,
  input  logic [7:0] minute_tens_char_i,
  input  logic [7:0] minute_ones_char_i,
  input  logic [7:0] second_tens_char_i,
  input  logic [7:0] second_ones_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o
);

  logic       inq_valid_q;
  logic [1:0] cmd_q;
  logic [7:0] hour_tens_q, hour_ones_q;
  logic [7:0] minute_tens_q, minute_ones_q;
  logic [7:0] second_tens_q, second_ones_q;

  logic         take;
  logic         emit;
  logic         emit_ready;
  time_digits_t digits;
  emit_req_t    req;

  assign take       = inq_valid_q && (emit_ready || !emit);
  assign in_ready_o = !inq_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      inq_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q         <= cmd_i;
      hour_tens_q   <= hour_tens_char_i;
      hour_ones_q   <= hour_ones_char_i;
      minute_tens_q <= minute_tens_char_i;
      minute_ones_q <= minute_ones_char_i;
      second_tens_q <= second_tens_char_i;
      second_ones_q <= second_ones_char_i;
    end
  end

  wchms_time u_time (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .take_i             (take),
    .cmd_i              (cmd_q),
    .hour_tens_char_i   (hour_tens_q),
    .hour_ones_char_i   (hour_ones_q),
    .minute_tens_char_i (minute_tens_q),
    .minute_ones_char_i (minute_ones_q),
    .second_tens_char_i (second_tens_q),
    .second_ones_char_i (second_ones_q),
    .emit_o             (emit),
    .digits_o           (digits)
  );

  assign req.load   = take && emit;
  assign req.digits = digits;

  wchms_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .ready_o     (emit_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import wchms_pkg::*;

  localparam int NumDir = 25;
  localparam int RandWords = 325;
  localparam int IdleLimit = 2000;
  localparam bit [4:0] HourWrap = 5'd24;
  localparam bit [5:0] MinSecWrap = 6'd60;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_SHOWS} row_kind_e;
  typedef enum logic [1:0] {EFF_SHOW, EFF_STOP, EFF_IGNORE} eff_e;

  typedef struct packed {
    cmd_e      cmd;
    bit [47:0] chars;
    row_kind_e kind;
    bit [63:0] txt;
  } row_t;

  typedef struct packed {
    bit [7:0] ch;
    bit       last;
  } disp_byte_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] cmd_i;
  logic [7:0] hour_tens_char_i;
  logic [7:0] hour_ones_char_i;
  logic [7:0] minute_tens_char_i;
  logic [7:0] minute_ones_char_i;
  logic [7:0] second_tens_char_i;
  logic [7:0] second_ones_char_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_char_o;
  logic       last_char_o;

  wall_clock_hms_ascii_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .cmd_i              (cmd_i),
    .hour_tens_char_i   (hour_tens_char_i),
    .hour_ones_char_i   (hour_ones_char_i),
    .minute_tens_char_i (minute_tens_char_i),
    .minute_ones_char_i (minute_ones_char_i),
    .second_tens_char_i (second_tens_char_i),
    .second_ones_char_i (second_ones_char_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_char_o         (out_char_o),
    .last_char_o        (last_char_o)
  );

  bit [4:0] clk_hrs;
  bit [5:0] clk_min;
  bit [5:0] clk_sec;
  bit       clk_on;

  disp_byte_t pending_chars[$];
  row_t       dir_rows [NumDir];

  int err_cnt;
  int bytes_checked;
  int burst_left;
  int cnt_set_ok, cnt_set_bad, cnt_get, cnt_stop, cnt_tick_shown, cnt_tick_idle;
  int cnt_midnight;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s at byte %0d: got 0x%0h, want 0x%0h", what, bytes_checked, got, want);
    err_cnt++;
  endtask

  function automatic int digit_pair(bit [7:0] tens, bit [7:0] ones);
    return (int'(tens) - int'(CharZero)) * 10 + (int'(ones) - int'(CharZero));
  endfunction

  function automatic eff_e apply_command(cmd_e c, bit [47:0] ch);
    int h, m, s;
    eff_e eff;
    h = digit_pair(ch[47:40], ch[39:32]);
    m = digit_pair(ch[31:24], ch[23:16]);
    s = digit_pair(ch[15:8], ch[7:0]);
    eff = EFF_SHOW;
    case (c)
      CMD_SET: begin
        if (h >= 0 && h < int'(HourWrap) && m >= 0 && m < int'(MinSecWrap) &&
            s >= 0 && s < int'(MinSecWrap)) begin
          clk_hrs = h[4:0];
          clk_min = m[5:0];
          clk_sec = s[5:0];
          clk_on = 1'b1;
        end else begin
          eff = EFF_IGNORE;
        end
      end
      CMD_GET: eff = EFF_SHOW;
      CMD_STOP: begin
        clk_on = 1'b0;
        eff = EFF_STOP;
      end
      default: begin
        if (!clk_on) begin
          eff = EFF_IGNORE;
        end else begin
          clk_sec = clk_sec + 6'd1;
          if (clk_sec >= MinSecWrap) begin
            clk_sec = 6'd0;
            clk_min = clk_min + 6'd1;
            if (clk_min >= MinSecWrap) begin
              clk_min = 6'd0;
              clk_hrs = clk_hrs + 5'd1;
              if (clk_hrs >= HourWrap) begin
                clk_hrs = 5'd0;
                cnt_midnight++;
              end
            end
          end
        end
      end
    endcase
    return eff;
  endfunction

  function automatic bit [63:0] time_text();
    return {CharZero + 8'(clk_hrs / 10), CharZero + 8'(clk_hrs % 10), CharColon,
            CharZero + 8'(clk_min / 10), CharZero + 8'(clk_min % 10), CharColon,
            CharZero + 8'(clk_sec / 10), CharZero + 8'(clk_sec % 10)};
  endfunction

  task automatic push_text(input bit [63:0] txt);
    pending_chars.push_back('{CharCr, 1'b0});
    for (int i = 7; i >= 0; i--) begin
      pending_chars.push_back('{txt[i*8 +: 8], 1'b0});
    end
    pending_chars.push_back('{CharCr, 1'b0});
    pending_chars.push_back('{CharNul, 1'b1});
  endtask

  function automatic bit [47:0] random_set_chars();
    bit [47:0] ch;
    bit [4:0] h;
    bit [5:0] m, s;
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      h = ($urandom_range(0, 2) == 0) ? 5'd23 : 5'($urandom_range(0, 23));
      m = ($urandom_range(0, 1) == 0) ? 6'd59 : 6'($urandom_range(0, 59));
      s = ($urandom_range(0, 1) == 0) ? 6'($urandom_range(50, 59)) : 6'($urandom_range(0, 59));
      ch = {CharZero + 8'(h / 10), CharZero + 8'(h % 10), CharZero + 8'(m / 10),
            CharZero + 8'(m % 10), CharZero + 8'(s / 10), CharZero + 8'(s % 10)};
    end else if (r < 80) begin
      for (int i = 0; i < 6; i++) ch[i*8 +: 8] = CharZero + 8'($urandom_range(0, 9));
    end else if (r < 90) begin
      for (int i = 0; i < 6; i += 2) begin
        ch[i*8 +: 8] = 8'($urandom_range(8'h26, 8'h3F));
        ch[i*8+8 +: 8] = CharZero + 8'($urandom_range(0, 5));
      end
    end else begin
      ch = 48'({$urandom, $urandom});
    end
    return ch;
  endfunction

  task automatic run_word(input cmd_e c, input bit [47:0] ch, input row_kind_e kind,
                          input bit [63:0] txt, output eff_e eff);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i         <= 1'b1;
    cmd_i              <= c;
    hour_tens_char_i   <= ch[47:40];
    hour_ones_char_i   <= ch[39:32];
    minute_tens_char_i <= ch[31:24];
    minute_ones_char_i <= ch[23:16];
    second_tens_char_i <= ch[15:8];
    second_ones_char_i <= ch[7:0];
    do @(posedge clk_i); while (!in_ready_o);
    eff = apply_command(c, ch);
    case (kind)
      ROW_PREDICT: if (eff == EFF_SHOW) push_text(time_text());
      ROW_SHOWS:   push_text(txt);
      default: ;
    endcase
    case (c)
      CMD_SET:  if (eff == EFF_SHOW) cnt_set_ok++; else cnt_set_bad++;
      CMD_GET:  cnt_get++;
      CMD_STOP: cnt_stop++;
      default:  if (eff == EFF_SHOW) cnt_tick_shown++; else cnt_tick_idle++;
    endcase
  endtask

  always @(posedge clk_i) begin
    disp_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("byte with no string pending", out_char_o, 0);
      end else begin
        want = pending_chars.pop_front();
        if (out_char_o !== want.ch) report_mismatch("out_char", out_char_o, want.ch);
        if (last_char_o !== want.last) report_mismatch("last_char", last_char_o, want.last);
      end
      bytes_checked++;
    end
  end

  initial begin : rx_stall
    bit [7:0] pat;
    int span;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      span = $urandom_range(24, 96);
      for (int k = 0; k < span; k++) begin
        @(negedge clk_i);
        out_ready_i <= pat[k % 8];
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("Watchdog: no handshake for %0d cycles, %0d bytes outstanding",
             IdleLimit, pending_chars.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    eff_e eff;
    cmd_e c;
    int r;
    int counted;
    bit drained;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    cmd_i              = CMD_SET;
    hour_tens_char_i   = 8'h00;
    hour_ones_char_i   = 8'h00;
    minute_tens_char_i = 8'h00;
    minute_ones_char_i = 8'h00;
    second_tens_char_i = 8'h00;
    second_ones_char_i = 8'h00;
    clk_hrs = 5'd0;
    clk_min = 6'd0;
    clk_sec = 6'd0;
    clk_on  = 1'b0;
    burst_left = 0;
    counted = 0;
    drained = 1'b0;

    dir_rows = '{
      '{CMD_GET,  48'h0,             ROW_SHOWS,   "00:00:00"},
      '{CMD_TICK, 48'h0,             ROW_SILENT,  64'h0},
      '{CMD_STOP, 48'h0,             ROW_SILENT,  64'h0},
      '{CMD_SET,  "235958",          ROW_SHOWS,   "23:59:58"},
      '{CMD_TICK, 48'h0,             ROW_SHOWS,   "23:59:59"},
      '{CMD_TICK, 48'h0,             ROW_SHOWS,   "00:00:00"},
      '{CMD_SET,  "240000",          ROW_SILENT,  64'h0},
      '{CMD_SET,  "006000",          ROW_SILENT,  64'h0},
      '{CMD_SET,  "000060",          ROW_SILENT,  64'h0},
      '{CMD_SET,  48'hFFFF_FFFF_FFFF, ROW_SILENT,  64'h0},
      '{CMD_SET,  48'h0,             ROW_SILENT,  64'h0},
      '{CMD_GET,  48'hFFFF_FFFF_FFFF, ROW_SHOWS,   "00:00:00"},
      '{CMD_SET,  "1/1/1/",          ROW_SHOWS,   "09:09:09"},
      '{CMD_SET,  "0:0:0:",          ROW_SHOWS,   "10:10:10"},
      '{CMD_SET,  "/C/C/C",          ROW_PREDICT, 64'h0},
      '{CMD_TICK, 48'h0,             ROW_PREDICT, 64'h0},
      '{CMD_SET,  "005959",          ROW_SHOWS,   "00:59:59"},
      '{CMD_TICK, 48'h0,             ROW_SHOWS,   "01:00:00"},
      '{CMD_STOP, 48'h0,             ROW_SILENT,  64'h0},
      '{CMD_TICK, 48'h0,             ROW_SILENT,  64'h0},
      '{CMD_GET,  48'h0,             ROW_SHOWS,   "01:00:00"},
      '{CMD_SET,  "120000",          ROW_SHOWS,   "12:00:00"},
      '{CMD_SET,  "123459",          ROW_SHOWS,   "12:34:59"},
      '{CMD_TICK, 48'h0,             ROW_PREDICT, 64'h0},
      '{CMD_SET,  "235960",          ROW_SILENT,  64'h0}
    };

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDir; i++) begin
      run_word(dir_rows[i].cmd, dir_rows[i].chars, dir_rows[i].kind, dir_rows[i].txt, eff);
    end

    while (counted < RandWords) begin
      r = $urandom_range(0, 99);
      if (r < 14) c = CMD_SET;
      else if (r < 26) c = CMD_GET;
      else if (r < 32) c = CMD_STOP;
      else c = CMD_TICK;
      run_word(c, (c == CMD_SET) ? random_set_chars() : 48'({$urandom, $urandom}),
               ROW_PREDICT, 64'h0, eff);
      counted++;
      if (!drained && counted == RandWords / 2) begin
        // hold off until every pending string is out
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (pending_chars.size() != 0) @(posedge clk_i);
        drained = 1'b1;
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("Sent %0d sets (%0d loaded, %0d rejected), %0d gets, %0d stops",
             cnt_set_ok + cnt_set_bad, cnt_set_ok, cnt_set_bad, cnt_get, cnt_stop);
    $display("Ticks: %0d shown, %0d while stopped; %0d midnight rollovers; %0d bytes checked",
             cnt_tick_shown, cnt_tick_idle, cnt_midnight, bytes_checked);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wchms_pkg.sv
rtl/wchms_time.sv
rtl/wchms_emit.sv
rtl/wall_clock_hms_ascii_unit.sv
tb/sv/tb.sv
